// ----- rtl/hrm_pkg.sv -----
// ----------------------------------------------------------------------------
// hrm_pkg
// Shared types and constants of the Householder reflector generator.
// ----------------------------------------------------------------------------
`default_nettype none

package hrm_pkg;

  localparam int unsigned ELEM_W   = 32;
  localparam int unsigned SUM_W    = 64;
  localparam int unsigned ROOT_W   = 32;
  localparam int unsigned PM_W     = 29;
  localparam int unsigned NUM_W    = 59;
  localparam int unsigned DEN_W    = 62;
  localparam int unsigned QUO_W    = 33;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_FLOOR   = 2'd2;

  typedef enum logic [17:0] {
    S_LOAD   = 18'h00001,
    S_SQ_RD  = 18'h00002,
    S_SQ_MAG = 18'h00004,
    S_SQ_MUL = 18'h00008,
    S_SQ_ACC = 18'h00010,
    S_SQRT   = 18'h00020,
    S_SCALE  = 18'h00040,
    S_DN_RD  = 18'h00080,
    S_DN_PM  = 18'h00100,
    S_DN_MUL = 18'h00200,
    S_DN_ACC = 18'h00400,
    S_OUT_A  = 18'h00800,
    S_OUT_B  = 18'h01000,
    S_OUT_BD = 18'h02000,
    S_OUT_MUL = 18'h04000,
    S_DIV_GO = 18'h08000,
    S_DIV    = 18'h10000,
    S_EMIT   = 18'h20000
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/hrm_ram.sv -----
// ----------------------------------------------------------------------------
// hrm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hrm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- rtl/hrm_sqrt.sv -----
// ----------------------------------------------------------------------------
// hrm_sqrt
// Floor integer square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hrm_sqrt (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [hrm_pkg::SUM_W-1:0]    radicand,
  output logic                              done,
  output logic      [hrm_pkg::ROOT_W-1:0]   root
);

  logic                      busy_r;
  logic                      done_r;
  logic [hrm_pkg::SUM_W-1:0] a_r;
  logic [hrm_pkg::SUM_W-1:0] r_r;
  logic [hrm_pkg::SUM_W-1:0] bit_r;
  logic [hrm_pkg::SUM_W-1:0] trial;

  assign trial = r_r + bit_r;
  assign done  = done_r;
  assign root  = r_r[hrm_pkg::ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r == 64'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= radicand;
      r_r   <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      if (a_r >= trial) begin
        a_r <= a_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hrm_div.sv -----
// ----------------------------------------------------------------------------
// hrm_div
// Rounded Q30 ratio num * 2^30 / den by restoring division, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hrm_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [hrm_pkg::NUM_W-1:0]   num,
  input  wire logic [hrm_pkg::DEN_W-1:0]   den,
  output logic                             done,
  output logic      [hrm_pkg::QUO_W-1:0]   quo
);

  logic                        busy_r;
  logic                        done_r;
  logic [5:0]                  cnt_r;
  logic [hrm_pkg::DEN_W:0]     rem_r;
  logic [hrm_pkg::DEN_W-1:0]   den_r;
  logic [hrm_pkg::QUO_W:0]     q_r;
  logic [hrm_pkg::DEN_W:0]     rem_sh;
  logic [hrm_pkg::DEN_W:0]     den_x;
  logic [hrm_pkg::QUO_W:0]     q_rnd;

  assign rem_sh = (cnt_r < 6'd2) ? rem_r : (rem_r << 1);
  assign den_x  = {1'b0, den_r};
  assign q_rnd  = q_r + 34'd1;
  assign quo    = q_rnd[hrm_pkg::QUO_W:1];
  assign done   = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 6'd32) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= (hrm_pkg::DEN_W+1)'(num);
      den_r <= den;
      q_r   <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r < 6'd2) begin
        if (rem_sh >= den_x) begin
          rem_r <= rem_sh - den_x;
          q_r   <= q_r + 34'd1;
        end
      end else begin
        if (rem_sh >= den_x) begin
          rem_r <= rem_sh - den_x;
          q_r   <= {q_r[hrm_pkg::QUO_W-1:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          q_r   <= {q_r[hrm_pkg::QUO_W-1:0], 1'b0};
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/householder_reflector_matrix.sv -----
// ----------------------------------------------------------------------------
// householder_reflector_matrix
// Collects one matrix line and emits its Householder reflector, row-major.
//
//  channel | direction | words
//  in_     | input     | element_value, element_last
//  out_    | output    | h_value, h_row, h_col, h_last
//  cfg_    | input     | line_length, start_offset, norm_floor
//
// Elements are taken one a cycle while loading. After the last one the
// sequencer sums the squares of the reflected elements, takes the root in the
// root unit, checks it against the floor, scales the elements and sums their
// squares; each entry of the reflected block then runs through the divider,
// other entries do not. Input is held off until the last entry is taken.
// Reset is synchronous and clears control only; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module householder_reflector_matrix #(
  parameter int unsigned MAX_N = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [31:0]                in_element_value,
  input  wire logic                              in_element_last,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [31:0]                     out_h_value,
  output logic      [2:0]                        out_h_row,
  output logic      [2:0]                        out_h_col,
  output logic                                   out_h_last,
  input  wire logic                              cfg_wr_en,
  input  wire logic [hrm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [hrm_pkg::CFG_DAT_W-1:0]     cfg_wr_data
);

  localparam int unsigned AW = $clog2(MAX_N);
  localparam int unsigned CW = $clog2(MAX_N + 1);

  hrm_pkg::state_t state_r, state_nxt;

  logic [3:0]  line_length_r;
  logic [3:0]  start_offset_r;
  logic [30:0] norm_floor_r;

  logic [CW-1:0] count_r, valid_r, n_r, m_r, i_r, n_eff, cnt_after;
  logic [AW-1:0] off_r, r_r, c_r;
  logic          ident_r;
  logic [63:0]   sum_r, prod_r;
  logic [31:0]   mag_r, mag0_r, maxm_r, mod_r;
  logic [32:0]   v0, maxv, v0_r, magv;
  logic [2:0]    s_r, s_calc;
  logic [hrm_pkg::DEN_W-1:0] den_r, den_nxt;
  logic [hrm_pkg::PM_W-1:0]  pm, pm_r, pa_r, pb_r;
  logic          nega_r, negb_r;
  logic [64:0]   sum_add;
  logic [63:0]   sum_sat;
  logic [CW:0]   idx;
  logic [31:0]   w, mag;
  logic          neg, accept, last_i, blk, row_end, mat_end;

  logic          vec_we;
  logic [AW-1:0] vec_waddr;
  logic [31:0]   vec_rdata;
  logic          mag_we;
  logic [AW-1:0] mag_raddr;
  logic [33:0]   mag_wdata, mag_rdata;

  logic          sqrt_start, sqrt_done, div_start, div_done;
  logic [31:0]   sqrt_root;
  logic [hrm_pkg::QUO_W-1:0] quo;
  logic [33:0]   delta, hval;

  logic          out_valid_r, out_last_r;
  logic [31:0]   out_value_r;
  logic [2:0]    out_row_r, out_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r  <= 4'd8;
      start_offset_r <= 4'd0;
      norm_floor_r   <= 31'd1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        hrm_pkg::REG_LINE_LENGTH:  line_length_r  <= cfg_wr_data[3:0];
        hrm_pkg::REG_START_OFFSET: start_offset_r <= cfg_wr_data[3:0];
        hrm_pkg::REG_NORM_FLOOR:   norm_floor_r   <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (line_length_r == 4'd0) begin
      n_eff = CW'(1);
    end else if (32'(line_length_r) > MAX_N) begin
      n_eff = CW'(MAX_N);
    end else begin
      n_eff = CW'(line_length_r);
    end
  end

  assign in_ready  = (state_r == hrm_pkg::S_LOAD);
  assign accept    = in_valid && in_ready;
  assign cnt_after = (count_r < n_eff) ? count_r + CW'(1) : count_r;

  assign vec_we    = accept && (count_r < n_eff);
  assign vec_waddr = count_r[AW-1:0];
  assign idx       = (CW+1)'(off_r) + (CW+1)'(i_r);

  hrm_ram #(.WIDTH(32), .DEPTH(MAX_N)) u_vec_ram (
    .clk     (clk),
    .wr_en   (vec_we),
    .wr_addr (vec_waddr),
    .wr_data (in_element_value),
    .rd_addr (idx[AW-1:0]),
    .rd_data (vec_rdata)
  );

  assign w    = (idx < (CW+1)'(valid_r)) ? vec_rdata : 32'd0;
  assign neg  = w[31];
  assign mag  = neg ? (~w + 32'd1) : w;
  assign magv = (i_r == '0) ? v0_r : mag_rdata[32:0];
  assign pm   = hrm_pkg::PM_W'(magv >> s_r);

  always_comb begin
    mag_we    = 1'b0;
    mag_wdata = {neg, 1'b0, mag};
    mag_raddr = i_r[AW-1:0];
    if (state_r == hrm_pkg::S_SQ_MAG) begin
      mag_we = 1'b1;
    end else if (state_r == hrm_pkg::S_DN_PM) begin
      mag_we    = 1'b1;
      mag_wdata = {mag_rdata[33], 4'd0, pm};
    end
    if (state_r == hrm_pkg::S_OUT_A) begin
      mag_raddr = r_r - off_r;
    end else if (state_r == hrm_pkg::S_OUT_B) begin
      mag_raddr = c_r - off_r;
    end
  end

  hrm_ram #(.WIDTH(34), .DEPTH(MAX_N)) u_mag_ram (
    .clk     (clk),
    .wr_en   (mag_we),
    .wr_addr (i_r[AW-1:0]),
    .wr_data (mag_wdata),
    .rd_addr (mag_raddr),
    .rd_data (mag_rdata)
  );

  assign last_i     = (i_r + CW'(1)) == m_r;
  assign sqrt_start = (state_r == hrm_pkg::S_SQ_ACC) && last_i;
  assign div_start  = (state_r == hrm_pkg::S_DIV_GO);

  hrm_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sum_sat),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  hrm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({prod_r[hrm_pkg::NUM_W-2:0], 1'b0}),
    .den   (den_r),
    .done  (div_done),
    .quo   (quo)
  );

  assign sum_add = {1'b0, sum_r} + {1'b0, prod_r};
  assign sum_sat = sum_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_add[63:0];
  assign den_nxt = den_r + hrm_pkg::DEN_W'(prod_r);
  assign v0      = 33'(mag0_r) + 33'(mod_r);
  assign maxv    = (v0 > 33'(maxm_r)) ? v0 : 33'(maxm_r);

  always_comb begin
    s_calc = 3'd0;
    for (int k = 0; k < 4; k++) begin
      if ((maxv >> k) >= 33'h2000_0000) begin
        s_calc = 3'(k + 1);
      end
    end
  end

  assign blk     = !ident_r && (r_r >= off_r) && (c_r >= off_r);
  assign row_end = (CW'(c_r) + CW'(1)) == n_r;
  assign mat_end = row_end && ((CW'(r_r) + CW'(1)) == n_r);
  assign delta   = (r_r == c_r) ? 34'h0_4000_0000 : 34'd0;
  assign hval    = (nega_r != negb_r) ? delta + 34'(quo) : delta - 34'(quo);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hrm_pkg::S_LOAD: begin
        if (accept && in_element_last) begin
          state_nxt = (5'(start_offset_r) >= 5'(n_eff)) ? hrm_pkg::S_OUT_A
                                                        : hrm_pkg::S_SQ_RD;
        end
      end
      hrm_pkg::S_SQ_RD:  state_nxt = hrm_pkg::S_SQ_MAG;
      hrm_pkg::S_SQ_MAG: state_nxt = hrm_pkg::S_SQ_MUL;
      hrm_pkg::S_SQ_MUL: state_nxt = hrm_pkg::S_SQ_ACC;
      hrm_pkg::S_SQ_ACC: state_nxt = last_i ? hrm_pkg::S_SQRT : hrm_pkg::S_SQ_RD;
      hrm_pkg::S_SQRT:   if (sqrt_done) state_nxt = hrm_pkg::S_SCALE;
      hrm_pkg::S_SCALE: begin
        state_nxt = (mod_r < {1'b0, norm_floor_r}) ? hrm_pkg::S_OUT_A
                                                   : hrm_pkg::S_DN_RD;
      end
      hrm_pkg::S_DN_RD:  state_nxt = hrm_pkg::S_DN_PM;
      hrm_pkg::S_DN_PM:  state_nxt = hrm_pkg::S_DN_MUL;
      hrm_pkg::S_DN_MUL: state_nxt = hrm_pkg::S_DN_ACC;
      hrm_pkg::S_DN_ACC: state_nxt = last_i ? hrm_pkg::S_OUT_A : hrm_pkg::S_DN_RD;
      hrm_pkg::S_OUT_A:  state_nxt = blk ? hrm_pkg::S_OUT_B : hrm_pkg::S_EMIT;
      hrm_pkg::S_OUT_B:  state_nxt = hrm_pkg::S_OUT_BD;
      hrm_pkg::S_OUT_BD: state_nxt = hrm_pkg::S_OUT_MUL;
      hrm_pkg::S_OUT_MUL: state_nxt = hrm_pkg::S_DIV_GO;
      hrm_pkg::S_DIV_GO: state_nxt = hrm_pkg::S_DIV;
      hrm_pkg::S_DIV:    if (div_done) state_nxt = hrm_pkg::S_EMIT;
      hrm_pkg::S_EMIT: begin
        if (out_ready) begin
          state_nxt = mat_end ? hrm_pkg::S_LOAD : hrm_pkg::S_OUT_A;
        end
      end
      default: state_nxt = hrm_pkg::S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hrm_pkg::S_LOAD;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        count_r <= in_element_last ? '0 : cnt_after;
      end
      if (state_r == hrm_pkg::S_OUT_A && !blk) begin
        out_valid_r <= 1'b1;
      end else if (state_r == hrm_pkg::S_DIV && div_done) begin
        out_valid_r <= 1'b1;
      end else if (state_r == hrm_pkg::S_EMIT && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      hrm_pkg::S_LOAD: begin
        if (accept && in_element_last) begin
          valid_r <= (cnt_after < n_eff) ? cnt_after : n_eff;
          n_r     <= n_eff;
          off_r   <= start_offset_r[AW-1:0];
          m_r     <= n_eff - CW'(start_offset_r);
          ident_r <= 5'(start_offset_r) >= 5'(n_eff);
          i_r     <= '0;
          sum_r   <= '0;
          maxm_r  <= '0;
          r_r     <= '0;
          c_r     <= '0;
        end
      end
      hrm_pkg::S_SQ_MAG: begin
        mag_r <= mag;
        if (i_r == '0) begin
          mag0_r <= mag;
        end else if (mag > maxm_r) begin
          maxm_r <= mag;
        end
      end
      hrm_pkg::S_SQ_MUL: prod_r <= mag_r * mag_r;
      hrm_pkg::S_SQ_ACC: begin
        sum_r <= sum_sat;
        i_r   <= last_i ? '0 : i_r + CW'(1);
      end
      hrm_pkg::S_SQRT: if (sqrt_done) mod_r <= sqrt_root;
      hrm_pkg::S_SCALE: begin
        ident_r <= mod_r < {1'b0, norm_floor_r};
        v0_r    <= v0;
        s_r     <= s_calc;
        den_r   <= '0;
      end
      hrm_pkg::S_DN_PM:  pm_r <= pm;
      hrm_pkg::S_DN_MUL: prod_r <= 64'(pm_r) * 64'(pm_r);
      hrm_pkg::S_DN_ACC: begin
        den_r <= den_nxt;
        i_r   <= last_i ? '0 : i_r + CW'(1);
        if (last_i && den_nxt == '0) begin
          ident_r <= 1'b1;
        end
      end
      hrm_pkg::S_OUT_A: begin
        if (!blk) begin
          out_value_r <= delta[31:0];
          out_row_r   <= 3'(r_r);
          out_col_r   <= 3'(c_r);
          out_last_r  <= mat_end;
        end
      end
      hrm_pkg::S_OUT_B: begin
        pa_r   <= mag_rdata[hrm_pkg::PM_W-1:0];
        nega_r <= mag_rdata[33];
      end
      hrm_pkg::S_OUT_BD: begin
        pb_r   <= mag_rdata[hrm_pkg::PM_W-1:0];
        negb_r <= mag_rdata[33];
      end
      hrm_pkg::S_OUT_MUL: prod_r <= 64'(pa_r) * 64'(pb_r);
      hrm_pkg::S_DIV: begin
        if (div_done) begin
          out_value_r <= hval[31:0];
          out_row_r   <= 3'(r_r);
          out_col_r   <= 3'(c_r);
          out_last_r  <= mat_end;
        end
      end
      hrm_pkg::S_EMIT: begin
        if (out_ready) begin
          if (row_end) begin
            c_r <= '0;
            r_r <= r_r + AW'(1);
          end else begin
            c_r <= c_r + AW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_h_value = out_value_r;
  assign out_h_row   = out_row_r;
  assign out_h_col   = out_col_r;
  assign out_h_last  = out_last_r;

endmodule

`default_nettype wire

// ----- dv/hrm_reflector_checker.sv -----
// ----------------------------------------------------------------------------
// hrm_reflector_checker
// Watches the element, entry and register ports of the reflector generator,
// predicts every matrix entry from the accepted elements and compares the
// entries the block hands out, in order, field by field.
// ----------------------------------------------------------------------------
module hrm_reflector_checker #(
  parameter int unsigned MAX_N = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [31:0]                    in_element_value,
  input  logic                           in_element_last,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [31:0]                    out_h_value,
  input  logic [2:0]                     out_h_row,
  input  logic [2:0]                     out_h_col,
  input  logic                           out_h_last,
  input  logic                           cfg_wr_en,
  input  logic [hrm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hrm_pkg::CFG_DAT_W-1:0]  cfg_wr_data,
  output int                             pending,
  output int                             errors
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  row;
    logic [2:0]  col;
    logic        last;
  } entry_t;

  entry_t      entry_q[$];
  logic [3:0]  len_reg, off_reg;
  logic [30:0] floor_reg;
  logic [31:0] line_buf [MAX_N];
  int unsigned elem_cnt;

  function automatic logic [31:0] int_sqrt(input logic [63:0] a);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > a) b = b >> 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  function automatic logic [63:0] q30_ratio(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q, rem;
    q = 0;
    rem = num;
    if (rem >= den) begin rem = rem - den; q = q + 1; end
    if (rem >= den) begin rem = rem - den; q = q + 1; end
    for (int k = 0; k < 31; k++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    return (q + 1) >> 1;
  endfunction

  task automatic take_element(input logic [31:0] v, input logic lst);
    int unsigned n, nval, off, m, s;
    logic [63:0] mag [MAX_N];
    logic [63:0] pm [MAX_N];
    logic        neg [MAX_N];
    logic [63:0] sum, sq, maxm, den, w, q;
    logic [31:0] modulus;
    logic        ident;
    longint      val;
    entry_t      e;
    n = (len_reg == 0) ? 1 : (len_reg > MAX_N) ? MAX_N : len_reg;
    if (elem_cnt < n) begin
      line_buf[elem_cnt] = v;
      elem_cnt++;
    end
    if (!lst) return;
    nval = (elem_cnt < n) ? elem_cnt : n;
    elem_cnt = 0;
    off = off_reg;
    ident = (off >= n);
    m = ident ? 0 : n - off;
    sum = 0;
    for (int i = 0; i < m; i++) begin
      w = (off + i < nval) ? {32'd0, line_buf[off + i]} : 64'd0;
      neg[i] = w[31];
      mag[i] = neg[i] ? (64'h1_0000_0000 - w) : w;
      sq = mag[i] * mag[i];
      sum = (sum > ~sq) ? ~64'd0 : sum + sq;
    end
    modulus = int_sqrt(sum);
    if (!ident && modulus < {1'b0, floor_reg}) ident = 1'b1;
    den = 0;
    if (!ident) begin
      maxm = 0;
      s = 0;
      mag[0] = mag[0] + modulus;
      for (int i = 0; i < m; i++) if (mag[i] > maxm) maxm = mag[i];
      while ((maxm >> s) >= (64'd1 << 29)) s++;
      for (int i = 0; i < m; i++) begin
        pm[i] = mag[i] >> s;
        den = den + pm[i] * pm[i];
      end
      if (den == 0) ident = 1'b1;
    end
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        val = (r == c) ? (64'sd1 <<< 30) : 0;
        if (!ident && r >= off && c >= off) begin
          q = q30_ratio(2 * pm[r - off] * pm[c - off], den);
          val = (neg[r - off] != neg[c - off]) ? val + longint'(q) : val - longint'(q);
        end
        e.value = val[31:0];
        e.row = r[2:0];
        e.col = c[2:0];
        e.last = (r == n - 1) && (c == n - 1);
        entry_q.push_back(e);
      end
    end
  endtask

  always @(posedge clk) begin
    entry_t e;
    if (!rst_n) begin
      len_reg = 4'd8;
      off_reg = 4'd0;
      floor_reg = 31'd1;
      elem_cnt = 0;
      entry_q.delete();
      errors = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          hrm_pkg::REG_LINE_LENGTH:  len_reg = cfg_wr_data[3:0];
          hrm_pkg::REG_START_OFFSET: off_reg = cfg_wr_data[3:0];
          hrm_pkg::REG_NORM_FLOOR:   floor_reg = cfg_wr_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_element(in_element_value, in_element_last);
      if (out_valid && out_ready) begin
        if (entry_q.size() == 0) begin
          $error("unexpected word: value %h row %0d col %0d", out_h_value, out_h_row,
                 out_h_col);
          errors++;
        end else begin
          e = entry_q.pop_front();
          if (out_h_value !== e.value) begin
            $error("h_value: expected %h, actual %h", e.value, out_h_value);
            errors++;
          end
          if (out_h_row !== e.row) begin
            $error("h_row: expected %0d, actual %0d", e.row, out_h_row);
            errors++;
          end
          if (out_h_col !== e.col) begin
            $error("h_col: expected %0d, actual %0d", e.col, out_h_col);
            errors++;
          end
          if (out_h_last !== e.last) begin
            $error("h_last: expected %0d, actual %0d", e.last, out_h_last);
            errors++;
          end
        end
      end
    end
    pending = entry_q.size();
  end
endmodule

// ----- dv/tb_householder_reflector_matrix.sv -----
// ----------------------------------------------------------------------------
// tb_householder_reflector_matrix
// Feeds matrix lines under many register settings, with bursty input and a
// stalling receiver; the checker predicts and compares every reflector entry.
// ----------------------------------------------------------------------------
module tb_householder_reflector_matrix;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_N      = 8;
  localparam int          IDLE_LIMIT = 6000;
  localparam int          TARGET     = 410;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_element_value = '0;
  logic        in_element_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_h_value;
  logic [2:0]  out_h_row, out_h_col;
  logic        out_h_last;
  logic        cfg_wr_en = 1'b0;
  logic [hrm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [hrm_pkg::CFG_DAT_W-1:0] cfg_wr_data = '0;
  int          pending, errors;
  int          burst_left = 0;
  int          words_sent = 0;
  int          idle_cycles = 0;
  logic        hold_req = 1'b0;
  int          cur_len = 8;

  always #1 clk = ~clk;

  householder_reflector_matrix #(.MAX_N(MAX_N)) DUT (
    .clk, .rst_n, .in_valid, .in_ready, .in_element_value, .in_element_last,
    .out_valid, .out_ready, .out_h_value, .out_h_row, .out_h_col, .out_h_last,
    .cfg_wr_en, .cfg_index, .cfg_wr_data
  );

  hrm_reflector_checker #(.MAX_N(MAX_N)) u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_element_value, .in_element_last,
    .out_valid, .out_ready, .out_h_value, .out_h_row, .out_h_col, .out_h_last,
    .cfg_wr_en, .cfg_index, .cfg_wr_data, .pending, .errors
  );

  always @(posedge clk) begin
    int mode_left, mode, hold_left;
    if (!rst_n) begin
      out_ready <= 1'b0;
      mode_left = 0;
      hold_left = 0;
    end else if (hold_req && hold_left == 0) begin
      hold_left = 400;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= (hold_left == 0);
    end else begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_householder_reflector_matrix: errors");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [31:0] v, input logic lst);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    in_valid <= 1'b1;
    in_element_value <= v;
    in_element_last <= lst;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    words_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_config(input logic [3:0] len, input logic [3:0] off,
                            input logic [30:0] floor_v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= hrm_pkg::REG_LINE_LENGTH;
    cfg_wr_data <= {27'd0, len};
    @(posedge clk);
    cfg_index <= hrm_pkg::REG_START_OFFSET;
    cfg_wr_data <= {27'd0, off};
    @(posedge clk);
    cfg_index <= hrm_pkg::REG_NORM_FLOOR;
    cfg_wr_data <= floor_v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    cur_len = (len == 0) ? 1 : (len > MAX_N) ? MAX_N : len;
  endtask

  function automatic logic [31:0] rand_element;
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return 32'hffff_ffff;
      4, 5: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 18)
                                        : -$urandom_range(0, 1 << 18);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_line(input int count);
    for (int i = 0; i < count; i++) send_word(rand_element(), i == count - 1);
  endtask

  initial begin
    int cnt, lines;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(32'h8000_0000, 1'b0);
    send_word(32'h7fff_ffff, 1'b0);
    send_word(32'hffff_ffff, 1'b0);
    send_word(32'h0000_0001, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0001_0000, 1'b0);
    send_word(32'hfffe_0000, 1'b0);
    send_word(32'h1234_5678, 1'b1);
    set_config(4'd3, 4'd0, 31'd0);
    send_word(32'd0, 1'b0);
    send_word(32'd0, 1'b0);
    send_word(32'd0, 1'b1);
    set_config(4'd2, 4'd2, 31'd1);
    send_word(32'h0003_0000, 1'b0);
    send_word(32'hfff0_0000, 1'b1);
    set_config(4'd4, 4'd1, 31'd1);
    send_word(32'hffff_0000, 1'b0);
    send_word(32'h0002_0000, 1'b1);
    set_config(4'd2, 4'd0, 31'h7fff_ffff);
    send_word(32'h0100_0000, 1'b0);
    send_word(32'h0200_0000, 1'b1);
    set_config(4'd0, 4'd0, 31'd1);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h0000_0005, 1'b1);
    set_config(4'd15, 4'd15, 31'd1);
    send_word(32'h0005_0000, 1'b1);
    set_config(4'd2, 4'd1, 31'd1);
    send_word(32'hfffc_0000, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0003_0000, 1'b0);
    send_word(32'h0003_0000, 1'b1);

    lines = 0;
    while (words_sent < TARGET) begin
      if (lines % 6 == 0) begin
        case ($urandom_range(0, 9))
          0: set_config(4'd8, 4'($urandom_range(0, 2)), 31'd1);
          1: set_config($urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15)),
                        4'($urandom_range(0, 15)), 31'($urandom));
          2: set_config(4'($urandom_range(1, 4)), 4'($urandom_range(0, 5)), 31'd0);
          3: set_config(4'($urandom_range(1, 4)), 4'd0, 31'h7fff_ffff);
          default: set_config(4'($urandom_range(1, 4)), 4'($urandom_range(0, 3)),
                              $urandom_range(0, 1) ? 31'd1
                                                   : 31'($urandom_range(0, 1 << 20)));
        endcase
      end
      if (lines == 20 || lines == 70) hold_req <= 1'b1;
      if (lines == 21 || lines == 71) hold_req <= 1'b0;
      if (lines == 40) drain();
      case ($urandom_range(0, 9))
        0: cnt = $urandom_range(1, cur_len);
        1: cnt = cur_len + $urandom_range(1, 3);
        default: cnt = cur_len;
      endcase
      send_line(cnt);
      lines++;
    end

    drain();
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_householder_reflector_matrix: clean");
    end else begin
      $display("tb_householder_reflector_matrix: errors");
    end
    $finish;
  end
endmodule
